// ----- rtl/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the windowed stall detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 100;
  localparam int unsigned ProdW = 64;

  // 5^12, scales squared distance in (1/256 m)^2 against (mm/s * ms)^2
  localparam logic [31:0] Pow5x12 = 32'd244140625;

  localparam logic [15:0] WindowRst   = 16'd500;
  localparam logic [15:0] MinHistRst  = 16'd300;
  localparam logic [15:0] EnterRst    = 16'd800;
  localparam logic [15:0] ExitRst     = 16'd1200;
  localparam logic [7:0]  MinDeltaRst = 8'd8;

  // MAC schedule steps
  localparam logic [3:0] StepDx2    = 4'd0;
  localparam logic [3:0] StepDy2    = 4'd1;
  localparam logic [3:0] StepD2     = 4'd3;
  localparam logic [3:0] StepLhsLo  = 4'd4;
  localparam logic [3:0] StepLhsHi  = 4'd5;
  localparam logic [3:0] StepVs     = 4'd6;
  localparam logic [3:0] StepLhs    = 4'd7;
  localparam logic [3:0] StepVsTake = 4'd8;
  localparam logic [3:0] StepSqLL   = 4'd9;
  localparam logic [3:0] StepSqLH0  = 4'd10;
  localparam logic [3:0] StepSqLH1  = 4'd11;
  localparam logic [3:0] StepSqHH   = 4'd12;
  localparam logic [3:0] StepJudge  = 4'd14;

  typedef enum logic [2:0] {
    REG_WINDOW    = 3'd0,
    REG_MIN_HIST  = 3'd1,
    REG_ENTER     = 3'd2,
    REG_EXIT      = 3'd3,
    REG_MIN_DELTA = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_MAC,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } mac_shift_e;

  typedef struct packed {
    logic       vld;
    logic       clr;
    mac_shift_e sh;
  } mac_op_t;

  typedef struct packed {
    logic [15:0] ref_age_ms;
    logic [15:0] min_history_ms;
    logic [15:0] enter_speed_mm_s;
    logic [15:0] exit_speed_mm_s;
    logic [7:0]  min_delta_ms;
  } cfg_t;

  typedef struct packed {
    logic               present;
    logic [31:0]        now_ms;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic        stuck;
    logic        sample_taken;
    logic [15:0] span_ms;
  } out_word_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [31:0]        stamp;
  } ring_entry_t;

endpackage

`default_nettype wire

// ----- rtl/wsd_regs.sv -----
// ----------------------------------------------------------------------------
// wsd_regs
// APB-style configuration registers of the windowed stall detector.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsd_pkg::AddrW-1:0]   paddr,
  input  wire logic [wsd_pkg::DataW-1:0]   pwdata,
  output logic      [wsd_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output wsd_pkg::cfg_t                    cfg_o
);

  wsd_pkg::cfg_t     cfg_q, cfg_d;
  wsd_pkg::reg_idx_e idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = wsd_pkg::reg_idx_e'(paddr[wsd_pkg::AddrW-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        wsd_pkg::REG_WINDOW:    cfg_d.ref_age_ms       = pwdata[15:0];
        wsd_pkg::REG_MIN_HIST:  cfg_d.min_history_ms   = pwdata[15:0];
        wsd_pkg::REG_ENTER:     cfg_d.enter_speed_mm_s = pwdata[15:0];
        wsd_pkg::REG_EXIT:      cfg_d.exit_speed_mm_s  = pwdata[15:0];
        wsd_pkg::REG_MIN_DELTA: cfg_d.min_delta_ms     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wsd_pkg::REG_WINDOW:    prdata = {16'b0, cfg_q.ref_age_ms};
      wsd_pkg::REG_MIN_HIST:  prdata = {16'b0, cfg_q.min_history_ms};
      wsd_pkg::REG_ENTER:     prdata = {16'b0, cfg_q.enter_speed_mm_s};
      wsd_pkg::REG_EXIT:      prdata = {16'b0, cfg_q.exit_speed_mm_s};
      wsd_pkg::REG_MIN_DELTA: prdata = {24'b0, cfg_q.min_delta_ms};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_age_ms       <= wsd_pkg::WindowRst;
      cfg_q.min_history_ms   <= wsd_pkg::MinHistRst;
      cfg_q.enter_speed_mm_s <= wsd_pkg::EnterRst;
      cfg_q.exit_speed_mm_s  <= wsd_pkg::ExitRst;
      cfg_q.min_delta_ms     <= wsd_pkg::MinDeltaRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wsd_ring.sv -----
// ----------------------------------------------------------------------------
// wsd_ring
// Sample ring memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_ring #(
  parameter  int unsigned Depth = 32,
  localparam int unsigned AW    = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire wsd_pkg::ring_entry_t wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output wsd_pkg::ring_entry_t      rdata_o
);

  wsd_pkg::ring_entry_t mem [Depth];
  wsd_pkg::ring_entry_t rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wsd_mac.sv -----
// ----------------------------------------------------------------------------
// wsd_mac
// Shared 32x32 multiplier with a shifted 100-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_mac (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire wsd_pkg::mac_op_t          op_i,
  input  wire logic [31:0]               a_i,
  input  wire logic [31:0]               b_i,
  output logic      [wsd_pkg::AccW-1:0]  acc_o
);

  wsd_pkg::mac_op_t           op_q;
  logic [wsd_pkg::ProdW-1:0]  prod_q;
  logic [wsd_pkg::AccW-1:0]   prod_ext;
  logic [wsd_pkg::AccW-1:0]   addend;
  logic [wsd_pkg::AccW-1:0]   acc_q;

  assign acc_o    = acc_q;
  assign prod_ext = wsd_pkg::AccW'(prod_q);

  always_comb begin
    unique case (op_q.sh)
      wsd_pkg::SH_0:  addend = prod_ext;
      wsd_pkg::SH_32: addend = prod_ext << 32;
      wsd_pkg::SH_64: addend = prod_ext << 64;
      default:        addend = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (op_q.vld) begin
      acc_q <= (op_q.clr ? '0 : acc_q) + addend;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/windowed_stall_detector_unit.sv -----
// ----------------------------------------------------------------------------
// windowed_stall_detector_unit
// Stall verdict from net planar speed over a time window of stored samples.
// ----------------------------------------------------------------------------
// One result word per input word. A decision state first picks the path; an
// absent, seed or skipped tick then goes straight to loading the result. A
// stored tick then walks back over k ring entries, where k (1 to RingDepth-1)
// is the number of ring entries the backward walk reads at one entry per cycle
// from the ring memory port; next, the fixed schedule of the shared multiplier
// forms the squared distance, its scaled form and the squared speed-span
// product, and then the result is loaded. The result register loads only once
// the previous word has left it, so an output stall adds its length. The next
// word can be taken in the cycle after the result is loaded; the input stalls
// in every state but idle, so no new word is taken before that.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_stall_detector_unit #(
  parameter int unsigned RingDepth = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire wsd_pkg::in_word_t           in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output wsd_pkg::out_word_t               out_word_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsd_pkg::AddrW-1:0]   paddr,
  input  wire logic [wsd_pkg::DataW-1:0]   pwdata,
  output logic      [wsd_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned AW = $clog2(RingDepth);
  localparam int unsigned CW = $clog2(RingDepth + 1);

  wsd_pkg::cfg_t        cfg;
  wsd_pkg::state_e      state_q, state_d;
  wsd_pkg::in_word_t    in_q;
  wsd_pkg::out_word_t   res_q, res_d, out_q;
  wsd_pkg::ring_entry_t wdata, rdata;
  wsd_pkg::mac_op_t     mac_op;

  logic [AW-1:0] wslot_q, wslot_d, ra_q, ra_d, raddr, waddr, idx_prev, ra_prev;
  logic [CW-1:0] count_q, count_d, wi_q, wi_d, count_inc;
  logic [31:0]   last_q, last_d, span_q, span_d, age, mac_a, mac_b;
  logic [23:0]   adx_q, adx_d, ady_q, ady_d;
  logic [3:0]    step_q, step_d;
  logic [48:0]   d2_q, d2_d;
  logic [77:0]   lhs_q, lhs_d;
  logic [47:0]   vs_q, vs_d;
  logic [wsd_pkg::AccW-1:0] acc, lhs_ext, rhs;
  logic          stuck_q, stuck_d, out_vld_q, out_vld_d;
  logic          accept_in, skip, walk_stop, out_free, we, re, faster, slower;
  logic signed [24:0] dx, dy, ndx, ndy;
  logic [15:0]   speed;

  wsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wsd_ring #(
    .Depth (RingDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wsd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign in_stall_o  = (state_q != wsd_pkg::ST_IDLE);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_vld_q || !out_stall_i;

  assign skip      = (in_q.now_ms - last_q) < {24'b0, cfg.min_delta_ms};
  assign idx_prev  = (wslot_q == '0) ? AW'(RingDepth - 1) : wslot_q - 1'b1;
  assign ra_prev   = (ra_q == '0) ? AW'(RingDepth - 1) : ra_q - 1'b1;
  assign count_inc = (count_q == CW'(RingDepth)) ? count_q : count_q + 1'b1;
  assign age       = in_q.now_ms - rdata.stamp;
  assign walk_stop = (age >= {16'b0, cfg.ref_age_ms}) || (wi_q == count_q - 1'b1);

  assign dx  = {in_q.pos_x[23], in_q.pos_x} - {rdata.x[23], rdata.x};
  assign dy  = {in_q.pos_y[23], in_q.pos_y} - {rdata.y[23], rdata.y};
  assign ndx = -dx;
  assign ndy = -dy;

  assign wdata = '{x: in_q.pos_x, y: in_q.pos_y, stamp: in_q.now_ms};

  assign speed   = stuck_q ? cfg.exit_speed_mm_s : cfg.enter_speed_mm_s;
  assign lhs_ext = wsd_pkg::AccW'(lhs_q);
  assign rhs     = {acc[wsd_pkg::AccW-5:0], 4'b0};
  assign faster  = lhs_ext > rhs;
  assign slower  = lhs_ext < rhs;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsd_pkg::ST_IDLE: begin
        if (accept_in) state_d = wsd_pkg::ST_DECIDE;
      end
      wsd_pkg::ST_DECIDE: begin
        if (!in_q.present || count_q == '0 || skip) begin
          state_d = wsd_pkg::ST_RESULT;
        end else begin
          state_d = wsd_pkg::ST_WALK;
        end
      end
      wsd_pkg::ST_WALK: begin
        if (walk_stop) state_d = wsd_pkg::ST_MAC;
      end
      wsd_pkg::ST_MAC: begin
        if (step_q == wsd_pkg::StepJudge) state_d = wsd_pkg::ST_RESULT;
      end
      wsd_pkg::ST_RESULT: begin
        if (out_free) state_d = wsd_pkg::ST_IDLE;
      end
      default: state_d = wsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wslot_d   = wslot_q;
    count_d   = count_q;
    last_d    = last_q;
    stuck_d   = stuck_q;
    ra_d      = ra_q;
    wi_d      = wi_q;
    span_d    = span_q;
    adx_d     = adx_q;
    ady_d     = ady_q;
    step_d    = step_q;
    d2_d      = d2_q;
    lhs_d     = lhs_q;
    vs_d      = vs_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && out_stall_i;
    we        = 1'b0;
    waddr     = wslot_q;
    re        = 1'b0;
    raddr     = ra_prev;
    mac_op    = '{vld: 1'b0, clr: 1'b0, sh: wsd_pkg::SH_0};
    mac_a     = '0;
    mac_b     = '0;

    unique case (state_q)
      wsd_pkg::ST_IDLE: ;
      wsd_pkg::ST_DECIDE: begin
        res_d = '{stuck: 1'b0, sample_taken: 1'b0, span_ms: 16'b0};
        if (!in_q.present) begin
          count_d = '0;
          wslot_d = '0;
          last_d  = '0;
          stuck_d = 1'b0;
        end else if (count_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          wslot_d = AW'(1);
          count_d = CW'(1);
          last_d  = in_q.now_ms;
          stuck_d = 1'b0;
          res_d.sample_taken = 1'b1;
        end else if (skip) begin
          res_d.stuck = stuck_q;
        end else begin
          we      = 1'b1;
          waddr   = wslot_q;
          wslot_d = (wslot_q == AW'(RingDepth - 1)) ? '0 : wslot_q + 1'b1;
          count_d = count_inc;
          last_d  = in_q.now_ms;
          re      = 1'b1;
          raddr   = idx_prev;
          ra_d    = idx_prev;
          wi_d    = CW'(1);
        end
      end
      wsd_pkg::ST_WALK: begin
        if (walk_stop) begin
          span_d = age;
          adx_d  = dx[24] ? ndx[23:0] : dx[23:0];
          ady_d  = dy[24] ? ndy[23:0] : dy[23:0];
          step_d = '0;
        end else begin
          re    = 1'b1;
          raddr = ra_prev;
          ra_d  = ra_prev;
          wi_d  = wi_q + 1'b1;
        end
      end
      wsd_pkg::ST_MAC: begin
        step_d = step_q + 1'b1;
        unique case (step_q)
          wsd_pkg::StepDx2: begin
            mac_op = '{vld: 1'b1, clr: 1'b1, sh: wsd_pkg::SH_0};
            mac_a  = {8'b0, adx_q};
            mac_b  = {8'b0, adx_q};
          end
          wsd_pkg::StepDy2: begin
            mac_op = '{vld: 1'b1, clr: 1'b0, sh: wsd_pkg::SH_0};
            mac_a  = {8'b0, ady_q};
            mac_b  = {8'b0, ady_q};
          end
          wsd_pkg::StepD2: d2_d = acc[48:0];
          wsd_pkg::StepLhsLo: begin
            mac_op = '{vld: 1'b1, clr: 1'b1, sh: wsd_pkg::SH_0};
            mac_a  = d2_q[31:0];
            mac_b  = wsd_pkg::Pow5x12;
          end
          wsd_pkg::StepLhsHi: begin
            mac_op = '{vld: 1'b1, clr: 1'b0, sh: wsd_pkg::SH_32};
            mac_a  = {15'b0, d2_q[48:32]};
            mac_b  = wsd_pkg::Pow5x12;
          end
          wsd_pkg::StepVs: begin
            mac_op = '{vld: 1'b1, clr: 1'b1, sh: wsd_pkg::SH_0};
            mac_a  = {16'b0, speed};
            mac_b  = span_q;
          end
          wsd_pkg::StepLhs:    lhs_d = acc[77:0];
          wsd_pkg::StepVsTake: vs_d  = acc[47:0];
          wsd_pkg::StepSqLL: begin
            mac_op = '{vld: 1'b1, clr: 1'b1, sh: wsd_pkg::SH_0};
            mac_a  = vs_q[31:0];
            mac_b  = vs_q[31:0];
          end
          wsd_pkg::StepSqLH0, wsd_pkg::StepSqLH1: begin
            mac_op = '{vld: 1'b1, clr: 1'b0, sh: wsd_pkg::SH_32};
            mac_a  = vs_q[31:0];
            mac_b  = {16'b0, vs_q[47:32]};
          end
          wsd_pkg::StepSqHH: begin
            mac_op = '{vld: 1'b1, clr: 1'b0, sh: wsd_pkg::SH_64};
            mac_a  = {16'b0, vs_q[47:32]};
            mac_b  = {16'b0, vs_q[47:32]};
          end
          wsd_pkg::StepJudge: begin
            if (stuck_q) begin
              if (span_q != '0 && faster) stuck_d = 1'b0;
            end else if (span_q >= {16'b0, cfg.min_history_ms}) begin
              if (span_q == '0) begin
                stuck_d = (cfg.enter_speed_mm_s != '0);
              end else begin
                stuck_d = slower;
              end
            end
            res_d.stuck        = stuck_d;
            res_d.sample_taken = 1'b1;
            res_d.span_ms      = (span_q[31:16] != '0) ? 16'hFFFF : span_q[15:0];
          end
          default: ;
        endcase
      end
      wsd_pkg::ST_RESULT: begin
        if (out_free) out_vld_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wsd_pkg::ST_IDLE;
      wslot_q   <= '0;
      count_q   <= '0;
      last_q    <= '0;
      stuck_q   <= 1'b0;
      out_vld_q <= 1'b0;
      ra_q      <= '0;
      wi_q      <= '0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      wslot_q   <= wslot_d;
      count_q   <= count_d;
      last_q    <= last_d;
      stuck_q   <= stuck_d;
      out_vld_q <= out_vld_d;
      ra_q      <= ra_d;
      wi_q      <= wi_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) in_q <= in_word_i;
    if (state_q == wsd_pkg::ST_RESULT && out_free) out_q <= res_q;
    span_q <= span_d;
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    d2_q   <= d2_d;
    lhs_q  <= lhs_d;
    vs_q   <= vs_d;
    res_q  <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(RingDepth))
    else $error("sample count beyond ring depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wslot_q <= AW'(RingDepth - 1))
    else $error("write slot beyond ring depth");

  a_stuck_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |-> count_q >= CW'(2))
    else $error("stuck verdict without two stored samples");

  a_skip_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.sample_taken) |-> out_word_o.span_ms == '0)
    else $error("span reported on a word that stored no sample");

endmodule

`default_nettype wire

// ----- tb/tb_windowed_stall_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_stall_detector_unit
// Self-checking bench for the windowed stall detector. A directed table covers
// absent and seed ticks, skipped ticks, wrapped time stamps, saturated spans,
// zero spans and the register extremes. Random phases of motion-like tracks
// follow, each under its own register setting. Every result word is compared
// field by field with the table's word on typed rows, else with a bit-exact
// in-bench predictor, with random idling on the input and random output stall.
// ----------------------------------------------------------------------------

module tb_windowed_stall_detector_unit;

  localparam int unsigned RING_DEPTH  = 32;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 13;
  localparam int unsigned PHASE_WORDS = 150;
  localparam logic [127:0] SCALE_5POW12 = 128'd244140625;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    wsd_pkg::in_word_t  word;
    wsd_pkg::out_word_t want;
    wsd_pkg::reg_idx_e  idx;
    logic [31:0]        val;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  wsd_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  wsd_pkg::out_word_t out_word_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [wsd_pkg::AddrW-1:0] paddr = '0;
  logic [wsd_pkg::DataW-1:0] pwdata = '0;
  logic [wsd_pkg::DataW-1:0] prdata;
  logic pready;

  windowed_stall_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic signed [23:0] hist_x [RING_DEPTH];
  logic signed [23:0] hist_y [RING_DEPTH];
  logic [31:0]        hist_ms [RING_DEPTH];
  logic [4:0]         next_slot = '0;
  logic [5:0]         held_count = '0;
  logic [31:0]        last_taken_ms = '0;
  logic               stuck_now = 1'b0;
  wsd_pkg::cfg_t cfg_copy = '{wsd_pkg::WindowRst, wsd_pkg::MinHistRst, wsd_pkg::EnterRst,
                              wsd_pkg::ExitRst, wsd_pkg::MinDeltaRst};

  wsd_pkg::out_word_t verdict_queue [$];
  dir_row_t           directed_rows [$];
  wsd_pkg::out_word_t head_word;
  int unsigned mismatch_count = 0;
  int unsigned words_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  function automatic int speed_sign(logic [63:0] d2, logic [15:0] v, logic [31:0] s);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [63:0]  vs;
    lhs = 128'(d2) * SCALE_5POW12;
    vs  = 64'(v) * 64'(s);
    rhs = (128'(vs) * 128'(vs)) << 4;
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  function automatic wsd_pkg::out_word_t predict_tick(wsd_pkg::in_word_t w);
    wsd_pkg::out_word_t r;
    logic [4:0]  wr;
    logic [4:0]  ref_slot;
    logic [31:0] gap_ms;
    logic [31:0] span;
    longint      dx;
    longint      dy;
    logic [63:0] d2;
    bit          found;
    bit          slow;
    r = '0;
    if (!w.present) begin
      held_count    = '0;
      next_slot     = '0;
      last_taken_ms = '0;
      stuck_now     = 1'b0;
      return r;
    end
    if (held_count == 0) begin
      hist_x[0]     = w.pos_x;
      hist_y[0]     = w.pos_y;
      hist_ms[0]    = w.now_ms;
      next_slot     = 5'd1;
      held_count    = 6'd1;
      last_taken_ms = w.now_ms;
      stuck_now     = 1'b0;
      r.sample_taken = 1'b1;
      return r;
    end
    gap_ms = w.now_ms - last_taken_ms;
    if (gap_ms < 32'(cfg_copy.min_delta_ms)) begin
      r.stuck = stuck_now;
      return r;
    end
    last_taken_ms = w.now_ms;
    wr = next_slot;
    hist_x[wr]  = w.pos_x;
    hist_y[wr]  = w.pos_y;
    hist_ms[wr] = w.now_ms;
    next_slot = wr + 5'd1;
    if (held_count < RING_DEPTH) held_count = held_count + 6'd1;

    // walk back from the sample before the newest, stop at the first one old
    ref_slot = wr;
    found = 1'b0;
    for (int i = 1; i < RING_DEPTH; i++) begin
      if (!found && i < held_count) begin
        ref_slot = wr - 5'(i);
        gap_ms = w.now_ms - hist_ms[ref_slot];
        if (gap_ms >= 32'(cfg_copy.ref_age_ms)) found = 1'b1;
      end
    end

    span = w.now_ms - hist_ms[ref_slot];
    dx = longint'($signed(w.pos_x)) - longint'(hist_x[ref_slot]);
    dy = longint'($signed(w.pos_y)) - longint'(hist_y[ref_slot]);
    d2 = 64'(dx * dx) + 64'(dy * dy);

    if (stuck_now) begin
      if (span > 0 && speed_sign(d2, cfg_copy.exit_speed_mm_s, span) > 0) stuck_now = 1'b0;
    end else if (span >= 32'(cfg_copy.min_history_ms)) begin
      if (span == 0) slow = (cfg_copy.enter_speed_mm_s > 0);
      else slow = (speed_sign(d2, cfg_copy.enter_speed_mm_s, span) < 0);
      if (slow) stuck_now = 1'b1;
    end

    r.stuck        = stuck_now;
    r.sample_taken = 1'b1;
    r.span_ms      = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int jitter(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic logic [15:0] pick16(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic wsd_pkg::in_word_t make_word(logic p, logic [31:0] now, logic [23:0] x,
                                                  logic [23:0] y);
    wsd_pkg::in_word_t w;
    w.present = p;
    w.now_ms  = now;
    w.pos_x   = x;
    w.pos_y   = y;
    return w;
  endfunction

  function automatic void add_word(logic p, logic [31:0] now, logic [23:0] x, logic [23:0] y);
    dir_row_t row;
    row.kind = ROW_WORD;
    row.word = make_word(p, now, x, y);
    row.want = '0;
    row.idx  = wsd_pkg::REG_WINDOW;
    row.val  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic p, logic [31:0] now, logic [23:0] x, logic [23:0] y,
                                    logic st, logic taken, logic [15:0] span);
    dir_row_t row;
    row.kind = ROW_TYPED;
    row.word = make_word(p, now, x, y);
    row.want = '{st, taken, span};
    row.idx  = wsd_pkg::REG_WINDOW;
    row.val  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(wsd_pkg::reg_idx_e idx, logic [31:0] val);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.word = '0;
    row.want = '0;
    row.idx  = idx;
    row.val  = val;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at word %0d, %s: got %0h, want %0h", words_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_word(wsd_pkg::in_word_t w, bit typed, wsd_pkg::out_word_t want);
    int unsigned        gap;
    wsd_pkg::out_word_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_tick(w);
    verdict_queue.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdict_queue.size() != 0);
  endtask

  task automatic cfg_write(wsd_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      wsd_pkg::REG_WINDOW:    cfg_copy.ref_age_ms       = val[15:0];
      wsd_pkg::REG_MIN_HIST:  cfg_copy.min_history_ms   = val[15:0];
      wsd_pkg::REG_ENTER:     cfg_copy.enter_speed_mm_s = val[15:0];
      wsd_pkg::REG_EXIT:      cfg_copy.exit_speed_mm_s  = val[15:0];
      wsd_pkg::REG_MIN_DELTA: cfg_copy.min_delta_ms     = val[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_queue.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_word_o), '0);
      end else begin
        head_word = verdict_queue.pop_front();
        if (out_word_o.stuck !== head_word.stuck)
          report_mismatch("stuck", 32'(out_word_o.stuck), 32'(head_word.stuck));
        if (out_word_o.sample_taken !== head_word.sample_taken)
          report_mismatch("sample_taken", 32'(out_word_o.sample_taken),
                          32'(head_word.sample_taken));
        if (out_word_o.span_ms !== head_word.span_ms)
          report_mismatch("span_ms", 32'(out_word_o.span_ms), 32'(head_word.span_ms));
      end
      words_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** windowed_stall_detector_unit: FAILED **");
      $finish;
    end
  end

  initial begin : sink_stall
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    wsd_pkg::in_word_t w;
    int unsigned r;
    int unsigned seg_left;
    int unsigned dt;
    int          vx;
    int          vy;
    int          jit;
    bit          noise;
    logic [31:0] now_acc;
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] c_win;
    logic [15:0] c_hist;
    logic [15:0] c_enter;
    logic [15:0] c_exit;
    logic [7:0]  c_delta;

    // defaults after reset
    add_typed(1'b0, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 16'd0);
    add_typed(1'b1, 32'd1000, 24'd0, 24'd0, 1'b0, 1'b1, 16'd0);
    add_typed(1'b1, 32'd1003, 24'd0, 24'd0, 1'b0, 1'b0, 16'd0);
    add_typed(1'b1, 32'd1008, 24'd0, 24'd0, 1'b0, 1'b1, 16'd8);
    add_typed(1'b1, 32'd1200, 24'd0, 24'd0, 1'b0, 1'b1, 16'd200);
    add_typed(1'b1, 32'd1400, 24'd0, 24'd0, 1'b1, 1'b1, 16'd400);
    add_typed(1'b1, 32'd1405, 24'd0, 24'd0, 1'b1, 1'b0, 16'd0);
    add_word(1'b1, 32'd1600, 24'h7FFFFF, 24'h800000);
    add_typed(1'b0, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 16'd0);
    // time stamp wrap, then a span beyond 16 bits
    add_typed(1'b1, 32'hFFFF_FFF0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 16'd0);
    add_word(1'b1, 32'h0000_0010, 24'h7FFFFF, 24'h800000);
    add_typed(1'b1, 32'd100016, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1, 16'hFFFF);
    // zero spans
    add_cfg(wsd_pkg::REG_MIN_HIST, 32'd0);
    add_cfg(wsd_pkg::REG_ENTER, 32'd65535);
    add_cfg(wsd_pkg::REG_EXIT, 32'd0);
    add_cfg(wsd_pkg::REG_MIN_DELTA, 32'd0);
    add_cfg(wsd_pkg::REG_WINDOW, 32'd65535);
    add_typed(1'b0, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 16'd0);
    add_typed(1'b1, 32'd5000, 24'd1, 24'd1, 1'b0, 1'b1, 16'd0);
    add_word(1'b1, 32'd5000, 24'd1, 24'd1);
    add_word(1'b1, 32'd5000, 24'h7FFFFF, 24'h7FFFFF);
    add_word(1'b1, 32'd5001, 24'h7FFFFF, 24'h7FFFFF);
    // widest skip distance, a 1 ms window, longest history
    add_cfg(wsd_pkg::REG_ENTER, 32'd0);
    add_cfg(wsd_pkg::REG_WINDOW, 32'd1);
    add_cfg(wsd_pkg::REG_MIN_DELTA, 32'd255);
    add_cfg(wsd_pkg::REG_MIN_HIST, 32'd65535);
    add_typed(1'b0, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 16'd0);
    add_typed(1'b1, 32'd0, 24'h123456, 24'hEDCBA9, 1'b0, 1'b1, 16'd0);
    add_typed(1'b1, 32'd254, 24'd0, 24'd0, 1'b0, 1'b0, 16'd0);
    add_typed(1'b1, 32'd255, 24'd0, 24'd0, 1'b0, 1'b1, 16'd255);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        drain_results();
        cfg_write(directed_rows[k].idx, directed_rows[k].val);
      end else begin
        push_word(directed_rows[k].word, directed_rows[k].kind == ROW_TYPED,
                  directed_rows[k].want);
      end
    end

    now_acc  = $urandom();
    px       = 24'($urandom());
    py       = 24'($urandom());
    seg_left = 0;
    vx = 0;
    vy = 0;
    jit = 0;
    noise = 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      calm = (phase % 4 == 3);
      if (phase == 0) begin
        c_win = 16'd1;
        c_hist = 16'd0;
        c_enter = 16'd0;
        c_exit = 16'd0;
        c_delta = 8'd0;
      end else if (phase == 1) begin
        c_win = 16'hFFFF;
        c_hist = 16'hFFFF;
        c_enter = 16'hFFFF;
        c_exit = 16'hFFFF;
        c_delta = 8'hFF;
      end else begin
        c_win = pick16(50, 1500);
        if (c_win == 0) c_win = 16'd1;
        c_hist  = pick16(0, 1000);
        c_enter = pick16(0, 3000);
        c_exit  = pick16(0, 4000);
        r = $urandom_range(0, 99);
        if (r < 10) c_delta = 8'd0;
        else if (r < 15) c_delta = 8'hFF;
        else c_delta = 8'($urandom_range(0, 40));
      end
      cfg_write(wsd_pkg::REG_WINDOW, 32'(c_win));
      cfg_write(wsd_pkg::REG_MIN_HIST, 32'(c_hist));
      cfg_write(wsd_pkg::REG_ENTER, 32'(c_enter));
      cfg_write(wsd_pkg::REG_EXIT, 32'(c_exit));
      cfg_write(wsd_pkg::REG_MIN_DELTA, 32'(c_delta));

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 60);
          noise = 1'b0;
          r = $urandom_range(0, 99);
          if (r < 30) begin
            vx = 0;
            vy = 0;
            jit = $urandom_range(0, 2);
          end else if (r < 60) begin
            vx = jitter(4);
            vy = jitter(4);
            jit = 1;
          end else if (r < 90) begin
            vx = jitter(40);
            vy = jitter(40);
            jit = 3;
          end else begin
            noise = 1'b1;
          end
        end
        seg_left--;

        r = $urandom_range(0, 99);
        if (r < 80) dt = $urandom_range(0, 2 * int'(cfg_copy.min_delta_ms) + 40);
        else if (r < 94) dt = $urandom_range(0, int'(cfg_copy.min_delta_ms));
        else if (r < 98) dt = $urandom_range(1000, 80000);
        else dt = $urandom();
        now_acc = now_acc + 32'(dt);

        if (noise) begin
          px = 24'($urandom());
          py = 24'($urandom());
        end else begin
          px = px + 24'(vx + jitter(jit));
          py = py + 24'(vy + jitter(jit));
        end

        w = make_word($urandom_range(0, 99) != 0, now_acc, px, py);
        push_word(w, 1'b0, '0);
      end
    end

    drain_results();
    calm = 1'b1;
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && verdict_queue.size() == 0) begin
      $display("** windowed_stall_detector_unit: PASSED **");
    end else begin
      $display("** windowed_stall_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule
